// File: rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Types and constants shared by the triangle plane slicer.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int COORD_W    = 32;
   localparam int NORMAL_W   = 24;
   localparam int OFFSET_W   = 56;
   localparam int PROD_W     = NORMAL_W + COORD_W;
   localparam int DIST_W     = 58;
   localparam int NUM_W      = DIST_W;
   localparam int DEN_W      = DIST_W + 1;
   localparam int REM_W      = DIST_W + 2;
   localparam int Q_W        = 33;
   localparam int DIV_STAGES = Q_W;
   localparam int MAX_SEGS   = 4;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NORMAL_X  = 3'd0,
      CSR_NORMAL_Y  = 3'd1,
      CSR_NORMAL_Z  = 3'd2,
      CSR_OFFSET    = 3'd3,
      CSR_HALF_EN   = 3'd4
   } csr_index_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef coord_type [2:0] point_type;
   typedef point_type [2:0] tri_type;

   typedef struct packed {
      point_type start_pt;
      point_type end_pt;
   } seg_type;

   typedef struct packed {
      tri_type    vert;
      logic [2:0] inplane;
      logic [2:0] hpok;
      logic       err;
      logic       two;
      logic [1:0] e0;
      logic [1:0] e1;
   } side_type;

endpackage

// File: rtl/tps_div.sv
// ----------------------------------------------------------------------------
// tps_div
// Pipelined restoring divider, one quotient bit per stage: num * 2^32 / den.
// ----------------------------------------------------------------------------
module tps_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [tps_pkg::NUM_W-1:0]    num,
   input  logic [tps_pkg::DEN_W-1:0]    den,
   output logic [tps_pkg::Q_W-1:0]      quot
);

   logic [tps_pkg::REM_W-1:0] r_ff   [0:tps_pkg::DIV_STAGES-1];
   logic [tps_pkg::DEN_W-1:0] den_ff [0:tps_pkg::DIV_STAGES-1];
   logic [tps_pkg::Q_W-1:0]   q_ff   [0:tps_pkg::DIV_STAGES-1];

   genvar i;
   generate
      for (i = 0; i < tps_pkg::DIV_STAGES; i++) begin : g_stage
         logic [tps_pkg::REM_W-1:0] r_in;
         logic [tps_pkg::REM_W-1:0] d_ext;
         logic [tps_pkg::DEN_W-1:0] d_in;
         logic [tps_pkg::Q_W-1:0]   q_prev;
         logic                      ge;
         if (i == 0) begin : g_first
            assign r_in   = tps_pkg::REM_W'(num);
            assign d_in   = den;
            assign q_prev = '0;
         end else begin : g_next
            assign r_in   = {r_ff[i-1][tps_pkg::REM_W-2:0], 1'b0};
            assign d_in   = den_ff[i-1];
            assign q_prev = q_ff[i-1];
         end
         assign d_ext = tps_pkg::REM_W'(d_in);
         assign ge    = (r_in >= d_ext);
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[i]   <= ge ? (r_in - d_ext) : r_in;
               den_ff[i] <= d_in;
               q_ff[i]   <= {q_prev[tps_pkg::Q_W-2:0], ge};
            end
         end
      end
   endgenerate

   assign quot = q_ff[tps_pkg::DIV_STAGES-1];

endmodule

// File: rtl/triangle_plane_slicer.sv
// ----------------------------------------------------------------------------
// triangle_plane_slicer
// Cuts one triangle per beat with a configured plane and returns 0..4 segments.
// ----------------------------------------------------------------------------
// A triangle is taken on a cycle with start high and busy low; its segments
// pass S1-S3, the 33-stage quotient pipeline, L0-L2, H1 and the output stage.
// Zero- or one-segment triangles flow at one per cycle unless a burst holds the
// pipeline. A triangle giving n segments (n >= 2) plays them out on consecutive
// cycles, stalling the pipeline (busy) until the last. Results cannot be held off.
// Registers may be written only while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_plane_slicer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [31:0]     req_first_x,
   input  logic signed [31:0]     req_first_y,
   input  logic signed [31:0]     req_first_z,
   input  logic signed [31:0]     req_second_x,
   input  logic signed [31:0]     req_second_y,
   input  logic signed [31:0]     req_second_z,
   input  logic signed [31:0]     req_third_x,
   input  logic signed [31:0]     req_third_y,
   input  logic signed [31:0]     req_third_z,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_start_x,
   output logic signed [31:0]     rsp_start_y,
   output logic signed [31:0]     rsp_start_z,
   output logic signed [31:0]     rsp_end_x,
   output logic signed [31:0]     rsp_end_y,
   output logic signed [31:0]     rsp_end_z,
   output logic                   rsp_last_segment,
   output logic                   rsp_count_error,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [55:0]            csr_data
);

   function automatic logic [1:0] next_idx(input logic [1:0] e);
      return (e == 2'd2) ? 2'd0 : e + 2'd1;
   endfunction

   // ---------------- configuration
   logic signed [23:0] nx_ff, ny_ff, nz_ff;
   logic signed [55:0] off_ff;
   logic               hp_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff    <= '0;
         ny_ff    <= 24'sd65536;
         nz_ff    <= '0;
         off_ff   <= '0;
         hp_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tps_pkg::CSR_NORMAL_X: nx_ff    <= csr_data[23:0];
            tps_pkg::CSR_NORMAL_Y: ny_ff    <= csr_data[23:0];
            tps_pkg::CSR_NORMAL_Z: nz_ff    <= csr_data[23:0];
            tps_pkg::CSR_OFFSET:   off_ff   <= csr_data;
            tps_pkg::CSR_HALF_EN:  hp_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control
   logic [2:0] o_cnt_ff;
   logic [1:0] o_idx_ff;
   logic       en;

   assign en   = (o_cnt_ff <= 3'd1);
   assign busy = !en;

   tps_pkg::tri_type vin;
   assign vin[0] = {req_first_z,  req_first_y,  req_first_x};
   assign vin[1] = {req_second_z, req_second_y, req_second_x};
   assign vin[2] = {req_third_z,  req_third_y,  req_third_x};

   // ---------------- S1: products
   logic                 s1_v_ff;
   tps_pkg::tri_type     s1_vert_ff;
   logic signed [55:0]   s1_dp_ff [0:2][0:2];
   logic signed [55:0]   s1_ha_ff [0:2];
   logic signed [55:0]   s1_hb_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= start;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_vert_ff <= vin;
         for (int v = 0; v < 3; v++) begin
            s1_dp_ff[v][0] <= nx_ff * $signed(vin[v][0]);
            s1_dp_ff[v][1] <= ny_ff * $signed(vin[v][1]);
            s1_dp_ff[v][2] <= nz_ff * $signed(vin[v][2]);
            s1_ha_ff[v]    <= ny_ff * $signed(vin[v][0]);
            s1_hb_ff[v]    <= nx_ff * $signed(vin[v][1]);
         end
      end
   end

   // ---------------- S2: distances
   logic                           s2_v_ff;
   tps_pkg::tri_type               s2_vert_ff;
   logic signed [tps_pkg::DIST_W-1:0] s2_d_ff [0:2];
   logic [2:0]                     s2_hpok_ff;

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [56:0] hd;
      if (en) begin
         s2_vert_ff <= s1_vert_ff;
         for (int v = 0; v < 3; v++) begin
            s2_d_ff[v] <= tps_pkg::DIST_W'(s1_dp_ff[v][0]) + tps_pkg::DIST_W'(s1_dp_ff[v][1])
                        + tps_pkg::DIST_W'(s1_dp_ff[v][2]) + tps_pkg::DIST_W'(off_ff);
            hd = 57'(s1_ha_ff[v]) - 57'(s1_hb_ff[v]);
            s2_hpok_ff[v] <= !hd[56];
         end
      end
   end

   // ---------------- S3: classify edges, pick crossings
   logic                        s3_v_ff;
   tps_pkg::side_type           s3_side_ff;
   logic [tps_pkg::NUM_W-1:0]   s3_num_ff [0:1];
   logic [tps_pkg::DEN_W-1:0]   s3_den_ff [0:1];

   logic [2:0] cr, inpl;
   logic [1:0] cnt, e0, e1;

   always_comb begin
      logic signed [tps_pkg::DIST_W-1:0] a, b;
      for (int e = 0; e < 3; e++) begin
         a = s2_d_ff[e];
         b = s2_d_ff[next_idx(2'(e))];
         inpl[e] = (a == 0) && (b == 0);
         cr[e]   = !((a > 0 && b > 0) || (a < 0 && b < 0)) && !inpl[e];
      end
      cnt = 2'(cr[0]) + 2'(cr[1]) + 2'(cr[2]);
      e0  = cr[0] ? 2'd0 : (cr[1] ? 2'd1 : 2'd2);
      e1  = (cr[0] && cr[1]) ? 2'd1 : 2'd2;
   end

   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else if (en) s3_v_ff <= s2_v_ff;
   end

   always_ff @(posedge clock) begin
      logic signed [tps_pkg::DIST_W-1:0] da, db;
      logic signed [tps_pkg::DEN_W-1:0]  df;
      logic [1:0]                        eh;
      if (en) begin
         s3_side_ff.vert    <= s2_vert_ff;
         s3_side_ff.inplane <= inpl;
         s3_side_ff.hpok    <= s2_hpok_ff;
         s3_side_ff.err     <= (cnt == 2'd1);
         s3_side_ff.two     <= (cnt >= 2'd2);
         s3_side_ff.e0      <= e0;
         s3_side_ff.e1      <= e1;
         for (int h = 0; h < 2; h++) begin
            eh = (h == 0) ? e0 : e1;
            da = s2_d_ff[eh];
            db = s2_d_ff[next_idx(eh)];
            df = tps_pkg::DEN_W'(db) - tps_pkg::DEN_W'(da);
            s3_num_ff[h] <= da[tps_pkg::DIST_W-1] ? tps_pkg::NUM_W'(-da) : tps_pkg::NUM_W'(da);
            s3_den_ff[h] <= df[tps_pkg::DEN_W-1] ? tps_pkg::DEN_W'(-df) : tps_pkg::DEN_W'(df);
         end
      end
   end

   // ---------------- D: crossing fractions
   logic [tps_pkg::Q_W-1:0] t0, t1;
   logic                    dv_ff    [0:tps_pkg::DIV_STAGES-1];
   tps_pkg::side_type       dside_ff [0:tps_pkg::DIV_STAGES-1];

   tps_div u_div0 (.clock(clock), .en(en), .num(s3_num_ff[0]), .den(s3_den_ff[0]), .quot(t0));
   tps_div u_div1 (.clock(clock), .en(en), .num(s3_num_ff[1]), .den(s3_den_ff[1]), .quot(t1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tps_pkg::DIV_STAGES; i++) dv_ff[i] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= s3_v_ff;
         for (int i = 1; i < tps_pkg::DIV_STAGES; i++) dv_ff[i] <= dv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dside_ff[0] <= s3_side_ff;
         for (int i = 1; i < tps_pkg::DIV_STAGES; i++) dside_ff[i] <= dside_ff[i-1];
      end
   end

   // ---------------- L0: edge differences
   logic                    l0_v_ff;
   tps_pkg::side_type       l0_side_ff;
   logic [tps_pkg::Q_W-1:0] l0_t_ff   [0:1];
   tps_pkg::point_type      l0_a_ff   [0:1];
   logic [2:0]              l0_neg_ff [0:1];
   logic [32:0]             l0_m_ff   [0:1][0:2];

   always_ff @(posedge clock) begin
      if (reset) l0_v_ff <= 1'b0;
      else if (en) l0_v_ff <= dv_ff[tps_pkg::DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      tps_pkg::side_type  sd;
      tps_pkg::point_type pa, pb;
      logic [1:0]         eh;
      logic signed [32:0] df;
      if (en) begin
         sd = dside_ff[tps_pkg::DIV_STAGES-1];
         l0_side_ff <= sd;
         l0_t_ff[0] <= t0;
         l0_t_ff[1] <= t1;
         for (int h = 0; h < 2; h++) begin
            eh = (h == 0) ? sd.e0 : sd.e1;
            pa = sd.vert[eh];
            pb = sd.vert[next_idx(eh)];
            l0_a_ff[h] <= pa;
            for (int k = 0; k < 3; k++) begin
               df = 33'($signed(pb[k])) - 33'($signed(pa[k]));
               l0_neg_ff[h][k] <= df[32];
               l0_m_ff[h][k]   <= df[32] ? 33'(-df) : 33'(df);
            end
         end
      end
   end

   // ---------------- L1: interpolation products
   logic               l1_v_ff;
   tps_pkg::side_type  l1_side_ff;
   tps_pkg::point_type l1_a_ff   [0:1];
   logic [2:0]         l1_neg_ff [0:1];
   logic [49:0]        l1_phi_ff [0:1][0:2];
   logic [48:0]        l1_plo_ff [0:1][0:2];

   always_ff @(posedge clock) begin
      if (reset) l1_v_ff <= 1'b0;
      else if (en) l1_v_ff <= l0_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_side_ff <= l0_side_ff;
         for (int h = 0; h < 2; h++) begin
            l1_a_ff[h]   <= l0_a_ff[h];
            l1_neg_ff[h] <= l0_neg_ff[h];
            for (int k = 0; k < 3; k++) begin
               l1_phi_ff[h][k] <= 50'(l0_m_ff[h][k]) * 50'(l0_t_ff[h][32:16]);
               l1_plo_ff[h][k] <= 49'(l0_m_ff[h][k]) * 49'(l0_t_ff[h][15:0]);
            end
         end
      end
   end

   // ---------------- L2: crossing points, saturated
   logic               l2_v_ff;
   tps_pkg::side_type  l2_side_ff;
   tps_pkg::point_type l2_hit_ff [0:1];

   always_ff @(posedge clock) begin
      if (reset) l2_v_ff <= 1'b0;
      else if (en) l2_v_ff <= l1_v_ff;
   end

   always_ff @(posedge clock) begin
      logic [50:0]        hi;
      logic [34:0]        step;
      logic signed [36:0] sum;
      if (en) begin
         l2_side_ff <= l1_side_ff;
         for (int h = 0; h < 2; h++) begin
            for (int k = 0; k < 3; k++) begin
               hi   = 51'(l1_phi_ff[h][k]) + 51'(l1_plo_ff[h][k][48:16]) + 51'h8000;
               step = hi[50:16];
               if (l1_neg_ff[h][k])
                  sum = 37'($signed(l1_a_ff[h][k])) - $signed({2'b00, step});
               else
                  sum = 37'($signed(l1_a_ff[h][k])) + $signed({2'b00, step});
               if (!sum[36] && (sum[35:31] != 5'b0))
                  l2_hit_ff[h][k] <= 32'sh7FFF_FFFF;
               else if (sum[36] && (sum[35:31] != 5'h1F))
                  l2_hit_ff[h][k] <= 32'sh8000_0000;
               else
                  l2_hit_ff[h][k] <= sum[31:0];
            end
         end
      end
   end

   // ---------------- H1: half-plane products for crossings
   logic               h1_v_ff;
   tps_pkg::side_type  h1_side_ff;
   tps_pkg::point_type h1_hit_ff [0:1];
   logic signed [55:0] h1_ha_ff  [0:1];
   logic signed [55:0] h1_hb_ff  [0:1];

   always_ff @(posedge clock) begin
      if (reset) h1_v_ff <= 1'b0;
      else if (en) h1_v_ff <= l2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_side_ff <= l2_side_ff;
         for (int h = 0; h < 2; h++) begin
            h1_hit_ff[h] <= l2_hit_ff[h];
            h1_ha_ff[h]  <= ny_ff * $signed(l2_hit_ff[h][0]);
            h1_hb_ff[h]  <= nx_ff * $signed(l2_hit_ff[h][1]);
         end
      end
   end

   // ---------------- segment list
   tps_pkg::seg_type bseg [0:tps_pkg::MAX_SEGS-1];
   logic [2:0]       bcnt;

   always_comb begin
      logic signed [56:0] hd;
      logic [1:0]         hok;
      tps_pkg::seg_type   cand [0:4];
      logic [4:0]         keep;
      logic [1:0]         nb;
      for (int h = 0; h < 2; h++) begin
         hd     = 57'(h1_ha_ff[h]) - 57'(h1_hb_ff[h]);
         hok[h] = !hd[56];
      end
      for (int e = 0; e < 3; e++) begin
         nb = next_idx(2'(e));
         cand[e].start_pt = h1_side_ff.vert[e];
         cand[e].end_pt   = h1_side_ff.vert[nb];
         keep[e] = h1_side_ff.inplane[e]
                 && (!hp_en_ff || (h1_side_ff.hpok[e] && h1_side_ff.hpok[nb]));
      end
      cand[3].start_pt = h1_hit_ff[0];
      cand[3].end_pt   = h1_hit_ff[1];
      keep[3] = h1_side_ff.two && (!hp_en_ff || (hok[0] && hok[1]));
      cand[4] = '0;
      keep[4] = h1_side_ff.err;
      for (int s = 0; s < tps_pkg::MAX_SEGS; s++) bseg[s] = '0;
      bcnt = '0;
      for (int c = 0; c < 5; c++) begin
         if (keep[c] && (bcnt < 3'(tps_pkg::MAX_SEGS))) begin
            bseg[bcnt[1:0]] = cand[c];
            bcnt = bcnt + 3'd1;
         end
      end
   end

   // ---------------- output stage
   tps_pkg::seg_type o_seg_ff [0:tps_pkg::MAX_SEGS-1];
   logic             o_err_ff;
   tps_pkg::seg_type cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         o_cnt_ff <= '0;
         o_idx_ff <= '0;
      end else if (en) begin
         o_cnt_ff <= h1_v_ff ? bcnt : 3'd0;
         o_idx_ff <= '0;
      end else begin
         o_cnt_ff <= o_cnt_ff - 3'd1;
         o_idx_ff <= o_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < tps_pkg::MAX_SEGS; s++) o_seg_ff[s] <= bseg[s];
         o_err_ff <= h1_side_ff.err;
      end
   end

   assign cur              = o_seg_ff[o_idx_ff];
   assign rsp_valid        = (o_cnt_ff != 3'd0);
   assign rsp_start_x      = cur.start_pt[0];
   assign rsp_start_y      = cur.start_pt[1];
   assign rsp_start_z      = cur.start_pt[2];
   assign rsp_end_x        = cur.end_pt[0];
   assign rsp_end_y        = cur.end_pt[1];
   assign rsp_end_z        = cur.end_pt[2];
   assign rsp_last_segment = (o_cnt_ff == 3'd1);
   assign rsp_count_error  = o_err_ff;

   // ---------------- checks
   a_busy_has_beat: assert property (@(posedge clock) disable iff (reset)
      busy |-> rsp_valid)
      else $error("busy without a pending result beat");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_segment |=> rsp_valid)
      else $error("segment burst broken before last beat");

   a_error_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_error && rsp_last_segment |->
         rsp_start_x == 0 && rsp_start_y == 0 && rsp_start_z == 0 &&
         rsp_end_x == 0 && rsp_end_y == 0 && rsp_end_z == 0)
      else $error("error beat carries coordinates");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      o_cnt_ff <= 3'(tps_pkg::MAX_SEGS))
      else $error("segment count out of range");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_plane_slicer. Triangles go in through the
// start/busy port and the plane is set up through the CSR channel while the
// block is idle. A local predictor computes the segments for each accepted
// triangle, and every result beat is checked field by field against the
// oldest pending segment.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      tps_pkg::seg_type seg;
      logic             last;
      logic             err;
   } slice_seg_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   tps_pkg::tri_type    tri_in;
   logic                rsp_valid;
   tps_pkg::coord_type  rsp_start_x, rsp_start_y, rsp_start_z;
   tps_pkg::coord_type  rsp_end_x, rsp_end_y, rsp_end_z;
   logic                rsp_last_segment;
   logic                rsp_count_error;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [55:0]         csr_data;

   // predictor copy of the plane registers
   longint     nrm_x, nrm_y, nrm_z, plane_off;
   bit         half_en;

   slice_seg_type      pending_segs[$];
   tps_pkg::seg_type   tri_segs[$];
   int                 mismatches;
   bit                 gaps_on;
   int                 plane_axis;   // -1: general plane, else only this normal axis set
   tps_pkg::coord_type plane_level;  // on-plane coordinate along plane_axis

   triangle_plane_slicer u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(tri_in[0][0]), .req_first_y(tri_in[0][1]),
      .req_first_z(tri_in[0][2]),
      .req_second_x(tri_in[1][0]), .req_second_y(tri_in[1][1]),
      .req_second_z(tri_in[1][2]),
      .req_third_x(tri_in[2][0]), .req_third_y(tri_in[2][1]),
      .req_third_z(tri_in[2][2]),
      .rsp_valid(rsp_valid),
      .rsp_start_x(rsp_start_x), .rsp_start_y(rsp_start_y), .rsp_start_z(rsp_start_z),
      .rsp_end_x(rsp_end_x), .rsp_end_y(rsp_end_y), .rsp_end_z(rsp_end_z),
      .rsp_last_segment(rsp_last_segment), .rsp_count_error(rsp_count_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   initial begin
      #600000;
      $display("Some tests failed");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint plane_distance(tps_pkg::point_type p);
      return nrm_x * longint'(p[0]) + nrm_y * longint'(p[1])
           + nrm_z * longint'(p[2]) + plane_off;
   endfunction

   function automatic bit [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic bit [63:0] crossing_fraction(bit [63:0] num, bit [63:0] den);
      bit [63:0] q, r, f;
      q = (num >= den) ? 64'd1 : 64'd0;
      r = q[0] ? num - den : num;
      f = '0;
      for (int i = 0; i < 32; i++) begin
         r = r << 1;
         f = f << 1;
         if (r >= den) begin
            r = r - den;
            f[0] = 1'b1;
         end
      end
      return (q << 32) | f;
   endfunction

   function automatic tps_pkg::coord_type lerp_coord(tps_pkg::coord_type a,
                                                     tps_pkg::coord_type b,
                                                     bit [63:0] t);
      longint    diff, res, step;
      bit [63:0] m, hi;
      diff = longint'(b) - longint'(a);
      m    = magnitude(diff);
      hi   = m * (t >> 16) + ((m * (t & 64'hFFFF)) >> 16) + 64'h8000;
      step = longint'(hi >> 16);
      res  = (diff < 0) ? longint'(a) - step : longint'(a) + step;
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return tps_pkg::coord_type'(res);
   endfunction

   function automatic bit radial_side(tps_pkg::point_type p);
      return (nrm_y * longint'(p[0]) - nrm_x * longint'(p[1])) >= 0;
   endfunction

   function automatic void keep_segment(tps_pkg::point_type a, tps_pkg::point_type b);
      tps_pkg::seg_type s;
      if (half_en && (!radial_side(a) || !radial_side(b))) return;
      if (tri_segs.size() >= tps_pkg::MAX_SEGS) return;
      s.start_pt = a;
      s.end_pt   = b;
      tri_segs.push_back(s);
   endfunction

   function automatic void predict_slices(tps_pkg::tri_type t);
      tps_pkg::point_type hits[2];
      tps_pkg::point_type a, b, hp;
      longint             da, db;
      bit [63:0]          frac;
      int                 nhit;
      bit                 err;
      slice_seg_type      e;
      tri_segs.delete();
      nhit = 0;
      for (int k = 0; k < 3; k++) begin
         a  = t[k];
         b  = t[(k + 1) % 3];
         da = plane_distance(a);
         db = plane_distance(b);
         if ((da > 0 && db > 0) || (da < 0 && db < 0)) continue;
         if (da == db) begin
            keep_segment(a, b);
            continue;
         end
         frac = crossing_fraction(magnitude(da), magnitude(db - da));
         for (int c = 0; c < 3; c++) hp[c] = lerp_coord(a[c], b[c], frac);
         if (nhit < 2) begin
            hits[nhit] = hp;
            nhit++;
         end
      end
      if (nhit == 2) keep_segment(hits[0], hits[1]);
      err = (nhit == 1);
      if (err && tri_segs.size() < tps_pkg::MAX_SEGS) tri_segs.push_back('0);
      foreach (tri_segs[i]) begin
         e.seg  = tri_segs[i];
         e.last = (i == tri_segs.size() - 1);
         e.err  = err;
         pending_segs.push_back(e);
      end
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      slice_seg_type e;
      if (!reset && rsp_valid) begin
         if (pending_segs.size() == 0) begin
            report_mismatch("unexpected beat", 1, 0);
         end else begin
            e = pending_segs.pop_front();
            if (rsp_start_x !== e.seg.start_pt[0])
               report_mismatch("start_x", rsp_start_x, e.seg.start_pt[0]);
            if (rsp_start_y !== e.seg.start_pt[1])
               report_mismatch("start_y", rsp_start_y, e.seg.start_pt[1]);
            if (rsp_start_z !== e.seg.start_pt[2])
               report_mismatch("start_z", rsp_start_z, e.seg.start_pt[2]);
            if (rsp_end_x !== e.seg.end_pt[0])
               report_mismatch("end_x", rsp_end_x, e.seg.end_pt[0]);
            if (rsp_end_y !== e.seg.end_pt[1])
               report_mismatch("end_y", rsp_end_y, e.seg.end_pt[1]);
            if (rsp_end_z !== e.seg.end_pt[2])
               report_mismatch("end_z", rsp_end_z, e.seg.end_pt[2]);
            if (rsp_last_segment !== e.last)
               report_mismatch("last_segment", rsp_last_segment, e.last);
            if (rsp_count_error !== e.err)
               report_mismatch("count_error", rsp_count_error, e.err);
         end
      end
   end

   // ---------------- driving ----------------
   task automatic send_triangle(tps_pkg::tri_type t);
      while (gaps_on && $urandom_range(99) < 15) @(negedge clock);
      start  = 1'b1;
      tri_in = t;
      do @(posedge clock); while (busy);
      predict_slices(t);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic write_csr(logic [2:0] idx, logic [55:0] value);
      while (gaps_on && $urandom_range(99) < 15) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tps_pkg::CSR_NORMAL_X: nrm_x     = longint'(signed'(value[23:0]));
         tps_pkg::CSR_NORMAL_Y: nrm_y     = longint'(signed'(value[23:0]));
         tps_pkg::CSR_NORMAL_Z: nrm_z     = longint'(signed'(value[23:0]));
         tps_pkg::CSR_OFFSET:   plane_off = longint'(signed'(value));
         tps_pkg::CSR_HALF_EN:  half_en   = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_segs.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // plane with coordinate[axis] = level (normal n on that axis), or a general plane when axis < 0
   task automatic set_plane(int axis, logic [23:0] n, tps_pkg::coord_type level,
                            logic [23:0] gx, logic [23:0] gy, logic [23:0] gz,
                            logic [55:0] goff, bit hp);
      longint off;
      wait_idle();
      plane_axis  = axis;
      plane_level = level;
      if (axis >= 0) begin
         off = -(longint'(signed'(n)) * longint'(level));
         write_csr(tps_pkg::CSR_NORMAL_X, (axis == 0) ? 56'(n) : '0);
         write_csr(tps_pkg::CSR_NORMAL_Y, (axis == 1) ? 56'(n) : '0);
         write_csr(tps_pkg::CSR_NORMAL_Z, (axis == 2) ? 56'(n) : '0);
         write_csr(tps_pkg::CSR_OFFSET, off[55:0]);
      end else begin
         write_csr(tps_pkg::CSR_NORMAL_X, 56'(gx));
         write_csr(tps_pkg::CSR_NORMAL_Y, 56'(gy));
         write_csr(tps_pkg::CSR_NORMAL_Z, 56'(gz));
         write_csr(tps_pkg::CSR_OFFSET, goff);
      end
      write_csr(tps_pkg::CSR_HALF_EN, 56'(hp));
   endtask

   function automatic tps_pkg::coord_type random_coord();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return tps_pkg::coord_type'($urandom_range(131072)) - 32'sd65536;
         3: return tps_pkg::coord_type'($urandom_range(4194304)) - 32'sd2097152;
         default: return tps_pkg::coord_type'($urandom);
      endcase
   endfunction

   function automatic tps_pkg::tri_type random_triangle();
      tps_pkg::tri_type t;
      for (int v = 0; v < 3; v++) begin
         for (int c = 0; c < 3; c++) t[v][c] = random_coord();
         if (plane_axis >= 0 && $urandom_range(2) == 0) t[v][plane_axis] = plane_level;
      end
      if (plane_axis >= 0 && $urandom_range(9) == 0)
         for (int v = 0; v < 3; v++) t[v][plane_axis] = plane_level;
      return t;
   endfunction

   // ---------------- tests ----------------
   task automatic test_reset_plane();
      tps_pkg::tri_type t;
      plane_axis  = 1;
      plane_level = '0;
      t = '{'{32'sd0, 32'sd65536, 32'sd0}, '{32'sd0, -32'sd65536, 32'sd0},
            '{32'sd65536, 32'sd65536, 32'sd0}};
      send_triangle(t);
      t = '{'{32'sd0, 32'sd0, 32'sd0}, '{32'sd65536, 32'sd0, 32'sd0},
            '{32'sd0, 32'sd0, 32'sd65536}};
      send_triangle(t);
      t = '{'{32'sd5, 32'sd0, 32'sd7}, '{32'sd9, 32'sd0, -32'sd3},
            '{32'sd1, 32'sd100, 32'sd0}};
      send_triangle(t);
      t = '{'{32'sd5, 32'sd0, 32'sd7}, '{32'sd9, 32'sd4, -32'sd3},
            '{32'sd1, 32'sd100, 32'sd0}};
      send_triangle(t);
      t = '{'{32'sd1, 32'sd3, 32'sd7}, '{32'sd9, 32'sd4, -32'sd3},
            '{32'sd1, 32'sd100, 32'sd0}};
      send_triangle(t);
   endtask

   task automatic test_extremes();
      tps_pkg::tri_type t;
      set_plane(1, 24'h010000, '0, '0, '0, '0, '0, 1'b0);
      t = '{'{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF},
            '{32'sh80000000, 32'sh80000000, 32'sh80000000},
            '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF}};
      send_triangle(t);
      t = '{'{32'sh80000000, 32'sh00000001, 32'sh7FFFFFFF},
            '{32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sh80000000},
            '{32'sh00000000, 32'sh7FFFFFFF, 32'sh00000000}};
      send_triangle(t);
      set_plane(-1, '0, '0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                56'h7FFFFFFFFFFFFF, 1'b0);
      for (int i = 0; i < 4; i++) send_triangle(random_triangle());
      set_plane(-1, '0, '0, 24'h800000, 24'h7FFFFF, 24'h800000,
                56'h80000000000000, 1'b0);
      for (int i = 0; i < 4; i++) send_triangle(random_triangle());
      // unused register indexes must leave the plane alone
      wait_idle();
      for (int k = 1; k <= 3; k++) write_csr(3'(tps_pkg::CSR_HALF_EN) + 3'(k), '1);
      for (int i = 0; i < 3; i++) send_triangle(random_triangle());
   endtask

   task automatic test_half_plane();
      tps_pkg::tri_type t;
      set_plane(2, 24'h010000, 32'sd65536, '0, '0, '0, '0, 1'b1);
      t = '{'{32'sd0, 32'sd0, 32'sd65536}, '{32'sd65536, -32'sd65536, 32'sd65536},
            '{32'sd65536, 32'sd65536, 32'sd0}};
      send_triangle(t);
      for (int i = 0; i < 6; i++) send_triangle(random_triangle());
      set_plane(0, 24'hFF0000, -32'sd131072, '0, '0, '0, '0, 1'b1);
      for (int i = 0; i < 6; i++) send_triangle(random_triangle());
   endtask

   task automatic test_random();
      int axis;
      for (int ph = 0; ph < 8; ph++) begin
         axis = $urandom_range(3) - 1;
         set_plane(axis, 24'($urandom), random_coord(), 24'($urandom), 24'($urandom),
                   24'($urandom), 56'({$urandom, $urandom}), 1'($urandom_range(1)));
         gaps_on = (ph != 3);
         for (int i = 0; i < 10; i++) send_triangle(random_triangle());
         gaps_on = 1'b1;
      end
   endtask

   initial begin
      mismatches = 0;
      gaps_on    = 1'b1;
      reset      = 1'b1;
      start      = 1'b0;
      tri_in     = '0;
      csr_valid  = 1'b0;
      csr_index  = tps_pkg::CSR_NORMAL_X;
      csr_data   = '0;
      nrm_x = 0; nrm_y = 65536; nrm_z = 0; plane_off = 0; half_en = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;
      test_reset_plane();
      test_extremes();
      test_half_plane();
      test_random();
      wait_idle();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/tps_pkg.sv
rtl/tps_div.sv
rtl/triangle_plane_slicer.sv
bench/testbench.sv
